// ===== rtl/awc_pkg.sv =====
// Shared types and constants for the associative write-back cache.
package awc_pkg;

  localparam int FUNC_W = 2;
  localparam int ADDR_W = 7;
  localparam int DATA_W = 8;
  localparam int LINE_W = 3;
  localparam int AGE_W  = 3;

  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

  // Operation codes carried on the func field
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WB,
    ST_FILL,
    ST_TOUCH,
    ST_LOAD,
    ST_RESP
  } state_t;

  // Outcome of one tag/age compare step
  typedef struct packed {
    logic hit;
    logic take;
    logic free;
  } cmp_res_t;

endpackage

// ===== rtl/awc_if.sv =====
// Valid/ready channel interfaces for request and result words.
interface awc_in_if;
  logic                         valid;
  logic                         ready;
  logic [awc_pkg::FUNC_W-1:0]   func;
  logic [awc_pkg::ADDR_W-1:0]   address;
  logic [awc_pkg::DATA_W-1:0]   write_data;

  modport source (output valid, output func, output address, output write_data,
                  input ready);
  modport sink   (input valid, input func, input address, input write_data,
                  output ready);
endinterface

interface awc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [awc_pkg::LINE_W-1:0]   line_used;
  logic [awc_pkg::DATA_W-1:0]   read_data;
  logic                         wrote_back;

  modport source (output valid, output hit, output line_used, output read_data,
                  output wrote_back, input ready);
  modport sink   (input valid, input hit, input line_used, input read_data,
                  input wrote_back, output ready);
endinterface

// ===== rtl/assoc_writeback_cache_lru_unit.sv =====
// Top level: fully associative write-back cache with age-based replacement.
// Request words arrive on in_ch (func, address, write_data); one result word
// per request leaves on out_ch (hit, line_used, read_data, wrote_back).
// Both channels move a word when valid and ready are high at a clock edge.
// One request is processed at a time; in_ch.ready is high only while idle.
// The tag scan uses one shared compare unit, one line per cycle, stopping on
// a hit. A dirty victim is copied back to backing memory before the block is
// filled from it, one byte at a time. Age update and the line access happen
// together in the touch state, and the result register is loaded after it.
// Read/write requests scan, refill on a miss, then touch; a direct load writes
// backing memory and an unused code goes straight to the result.
// The next request is accepted only once the sequencer is back in the idle
// state after a result is registered.
// The result stays in an output register; a new request is accepted while it
// waits, but the next result is held back until out_ch.ready takes the first.
// Synchronous reset clears line tags, valid, dirty and age bits and the
// channel state; cache data and backing memory hold unknown values until
// written. No clearing pass is needed.
module assoc_writeback_cache_lru_unit #(
  parameter int NUM_LINES   = 8,
  parameter int BLOCK_BYTES = 4,
  parameter int MEM_BYTES   = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  awc_in_if.sink     in_ch,
  awc_out_if.source  out_ch
);

  localparam int AW       = awc_pkg::ADDR_W;
  localparam int DW       = awc_pkg::DATA_W;
  localparam int LW       = $clog2(NUM_LINES);
  localparam int OW       = $clog2(BLOCK_BYTES);
  localparam int OFF_W    = (OW > 0) ? OW : 1;
  localparam int TAG_W    = AW - OW;
  localparam int CW       = $clog2(BLOCK_BYTES + 1);
  localparam int LD_DEPTH = NUM_LINES * BLOCK_BYTES;
  localparam int LDA_W    = $clog2(LD_DEPTH);
  localparam int MA_W     = $clog2(MEM_BYTES);
  localparam int XW       = AW + MA_W;

  // Line data address: line * BLOCK_BYTES + byte
  function automatic logic [LDA_W-1:0] lidx(input logic [LW-1:0] v,
                                            input logic [CW-1:0] j);
    logic [LDA_W-1:0] x;
    x = LDA_W'(v) * LDA_W'(BLOCK_BYTES) + LDA_W'(j);
    return x;
  endfunction

  // Backing memory address: (tag * BLOCK_BYTES + byte) wrapped to memory size
  function automatic logic [MA_W-1:0] bidx(input logic [TAG_W-1:0] t,
                                           input logic [CW-1:0] j);
    logic [XW-1:0] x;
    x = XW'(t) * XW'(BLOCK_BYTES) + XW'(j);
    return x[MA_W-1:0];
  endfunction

  awc_pkg::state_t state_r, state_nxt;

  logic [awc_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic [AW-1:0]              addr_r, addr_nxt;
  logic [DW-1:0]              wdata_r, wdata_nxt;
  logic [LW-1:0]              idx_r, idx_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       hit_r, hit_nxt;
  logic                       wb_r, wb_nxt;
  logic [LW-1:0]              line_r, line_nxt;
  logic [LW-1:0]              vic_r, vic_nxt;
  logic [TAG_W-1:0]           vtag_r, vtag_nxt;
  logic                       vwb_r, vwb_nxt;
  logic [awc_pkg::AGE_W-1:0]  best_r, best_nxt;
  logic                       free_r, free_nxt;

  logic [TAG_W-1:0]           ltag_r [NUM_LINES];
  logic [TAG_W-1:0]           ltag_nxt [NUM_LINES];
  logic                       lvalid_r [NUM_LINES];
  logic                       lvalid_nxt [NUM_LINES];
  logic                       ldirty_r [NUM_LINES];
  logic                       ldirty_nxt [NUM_LINES];
  logic [awc_pkg::AGE_W-1:0]  lage_r [NUM_LINES];
  logic [awc_pkg::AGE_W-1:0]  lage_nxt [NUM_LINES];

  logic                       ov_r, ov_nxt;
  logic                       ohit_r, ohit_nxt;
  logic [awc_pkg::LINE_W-1:0] oline_r, oline_nxt;
  logic [DW-1:0]              odata_r, odata_nxt;
  logic                       owb_r, owb_nxt;

  // RAM controls
  logic             lr_we, lr_re, br_we, br_re;
  logic [LDA_W-1:0] lr_waddr, lr_raddr;
  logic [MA_W-1:0]  br_waddr, br_raddr;
  logic [DW-1:0]    lr_wdata, lr_rdata, br_wdata, br_rdata;

  logic [TAG_W-1:0]   key;
  logic [OFF_W-1:0]   off;
  logic [XW-1:0]      addr_x;
  awc_pkg::cmp_res_t  cres;

  assign key    = TAG_W'(addr_r >> OW);
  assign off    = OFF_W'(addr_r & AW'(BLOCK_BYTES - 1));
  assign addr_x = XW'(addr_r);

  awc_cmp #(.TAG_W(TAG_W)) u_cmp (
    .first      (idx_r == '0),
    .valid      (lvalid_r[idx_r]),
    .tag        (ltag_r[idx_r]),
    .key        (key),
    .age        (lage_r[idx_r]),
    .best       (best_r),
    .found_free (free_r),
    .res        (cres)
  );

  awc_ram #(.WIDTH(DW), .DEPTH(LD_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (lr_we),
    .waddr (lr_waddr),
    .wdata (lr_wdata),
    .re    (lr_re),
    .raddr (lr_raddr),
    .rdata (lr_rdata)
  );

  awc_ram #(.WIDTH(DW), .DEPTH(MEM_BYTES)) u_back_ram (
    .clk   (clk),
    .we    (br_we),
    .waddr (br_waddr),
    .wdata (br_wdata),
    .re    (br_re),
    .raddr (br_raddr),
    .rdata (br_rdata)
  );

  assign in_ch.ready       = (state_r == awc_pkg::ST_IDLE);
  assign out_ch.valid      = ov_r;
  assign out_ch.hit        = ohit_r;
  assign out_ch.line_used  = oline_r;
  assign out_ch.read_data  = odata_r;
  assign out_ch.wrote_back = owb_r;

  // Sequencer: next state, datapath updates and RAM controls
  always_comb begin
    state_nxt  = state_r;
    func_nxt   = func_r;
    addr_nxt   = addr_r;
    wdata_nxt  = wdata_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    hit_nxt    = hit_r;
    wb_nxt     = wb_r;
    line_nxt   = line_r;
    vic_nxt    = vic_r;
    vtag_nxt   = vtag_r;
    vwb_nxt    = vwb_r;
    best_nxt   = best_r;
    free_nxt   = free_r;
    ltag_nxt   = ltag_r;
    lvalid_nxt = lvalid_r;
    ldirty_nxt = ldirty_r;
    lage_nxt   = lage_r;
    ov_nxt     = ov_r;
    ohit_nxt   = ohit_r;
    oline_nxt  = oline_r;
    odata_nxt  = odata_r;
    owb_nxt    = owb_r;
    lr_we      = 1'b0;
    lr_re      = 1'b0;
    lr_waddr   = '0;
    lr_raddr   = '0;
    lr_wdata   = '0;
    br_we      = 1'b0;
    br_re      = 1'b0;
    br_waddr   = '0;
    br_raddr   = '0;
    br_wdata   = '0;

    // result word taken
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      awc_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          func_nxt  = in_ch.func;
          addr_nxt  = in_ch.address;
          wdata_nxt = in_ch.write_data;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          wb_nxt    = 1'b0;
          line_nxt  = '0;
          case (in_ch.func)
            awc_pkg::FN_READ, awc_pkg::FN_WRITE: state_nxt = awc_pkg::ST_SCAN;
            awc_pkg::FN_LOAD:                    state_nxt = awc_pkg::ST_LOAD;
            default:                             state_nxt = awc_pkg::ST_RESP;
          endcase
        end
      end

      // one line per cycle through the shared compare unit
      awc_pkg::ST_SCAN: begin
        if (cres.take) begin
          vic_nxt  = idx_r;
          vtag_nxt = ltag_r[idx_r];
          vwb_nxt  = lvalid_r[idx_r] && ldirty_r[idx_r];
          best_nxt = lage_r[idx_r];
          free_nxt = cres.free;
        end
        if (cres.hit) begin
          hit_nxt   = 1'b1;
          line_nxt  = idx_r;
          state_nxt = awc_pkg::ST_TOUCH;
        end else if (idx_r == LW'(NUM_LINES - 1)) begin
          line_nxt  = vic_nxt;
          wb_nxt    = vwb_nxt;
          cnt_nxt   = '0;
          state_nxt = vwb_nxt ? awc_pkg::ST_WB : awc_pkg::ST_FILL;
        end else begin
          idx_nxt = idx_r + LW'(1);
        end
      end

      // copy dirty victim to backing memory, read one byte ahead
      awc_pkg::ST_WB: begin
        if (cnt_r != CW'(BLOCK_BYTES)) begin
          lr_re    = 1'b1;
          lr_raddr = lidx(vic_r, cnt_r);
        end
        if (cnt_r != '0) begin
          br_we    = 1'b1;
          br_waddr = bidx(vtag_r, cnt_r - CW'(1));
          br_wdata = lr_rdata;
        end
        if (cnt_r == CW'(BLOCK_BYTES)) begin
          cnt_nxt   = '0;
          state_nxt = awc_pkg::ST_FILL;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      // fill the line from backing memory
      awc_pkg::ST_FILL: begin
        if (cnt_r != CW'(BLOCK_BYTES)) begin
          br_re    = 1'b1;
          br_raddr = bidx(key, cnt_r);
        end
        if (cnt_r != '0) begin
          lr_we    = 1'b1;
          lr_waddr = lidx(vic_r, cnt_r - CW'(1));
          lr_wdata = br_rdata;
        end
        if (cnt_r == CW'(BLOCK_BYTES)) begin
          cnt_nxt           = '0;
          ltag_nxt[vic_r]   = key;
          lvalid_nxt[vic_r] = 1'b1;
          ldirty_nxt[vic_r] = 1'b0;
          state_nxt         = awc_pkg::ST_TOUCH;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      // age all lines, then write the byte or start the read
      awc_pkg::ST_TOUCH: begin
        for (int i = 0; i < NUM_LINES; i++) begin
          if (LW'(i) == line_r) begin
            lage_nxt[i] = '0;
          end else if (lage_r[i] < awc_pkg::AGE_MAX) begin
            lage_nxt[i] = lage_r[i] + awc_pkg::AGE_W'(1);
          end
        end
        if (func_r == awc_pkg::FN_WRITE) begin
          lr_we              = 1'b1;
          lr_waddr           = lidx(line_r, CW'(off));
          lr_wdata           = wdata_r;
          ldirty_nxt[line_r] = 1'b1;
        end else begin
          lr_re    = 1'b1;
          lr_raddr = lidx(line_r, CW'(off));
        end
        state_nxt = awc_pkg::ST_RESP;
      end

      // direct write into backing memory
      awc_pkg::ST_LOAD: begin
        br_we     = 1'b1;
        br_waddr  = addr_x[MA_W-1:0];
        br_wdata  = wdata_r;
        state_nxt = awc_pkg::ST_RESP;
      end

      // hand the word to the output register once it is free
      awc_pkg::ST_RESP: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          ohit_nxt  = hit_r;
          oline_nxt = awc_pkg::LINE_W'(line_r);
          owb_nxt   = wb_r;
          case (func_r)
            awc_pkg::FN_READ:                  odata_nxt = lr_rdata;
            awc_pkg::FN_WRITE, awc_pkg::FN_LOAD: odata_nxt = wdata_r;
            default:                           odata_nxt = '0;
          endcase
          state_nxt = awc_pkg::ST_IDLE;
        end
      end

      default: state_nxt = awc_pkg::ST_IDLE;
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= awc_pkg::ST_IDLE;
      ov_r    <= 1'b0;
      for (int i = 0; i < NUM_LINES; i++) begin
        ltag_r[i]   <= '0;
        lvalid_r[i] <= 1'b0;
        ldirty_r[i] <= 1'b0;
        lage_r[i]   <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      ov_r     <= ov_nxt;
      ltag_r   <= ltag_nxt;
      lvalid_r <= lvalid_nxt;
      ldirty_r <= ldirty_nxt;
      lage_r   <= lage_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    addr_r  <= addr_nxt;
    wdata_r <= wdata_nxt;
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    hit_r   <= hit_nxt;
    wb_r    <= wb_nxt;
    line_r  <= line_nxt;
    vic_r   <= vic_nxt;
    vtag_r  <= vtag_nxt;
    vwb_r   <= vwb_nxt;
    best_r  <= best_nxt;
    free_r  <= free_nxt;
    ohit_r  <= ohit_nxt;
    oline_r <= oline_nxt;
    odata_r <= odata_nxt;
    owb_r   <= owb_nxt;
  end

endmodule

// ===== rtl/awc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module awc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/awc_cmp.sv =====
// Shared compare unit: tag match and victim selection for one line per step.
module awc_cmp #(
  parameter int TAG_W = 5
) (
  input  logic                        first,
  input  logic                        valid,
  input  logic [TAG_W-1:0]            tag,
  input  logic [TAG_W-1:0]            key,
  input  logic [awc_pkg::AGE_W-1:0]   age,
  input  logic [awc_pkg::AGE_W-1:0]   best,
  input  logic                        found_free,
  output awc_pkg::cmp_res_t           res
);

  always_comb begin
    res.hit  = valid && (tag == key);
    res.take = 1'b0;
    res.free = found_free;
    // first line seeds the victim; then first invalid, else first oldest
    if (first) begin
      res.take = 1'b1;
      res.free = ~valid;
    end else if (found_free) begin
      res.take = 1'b0;
    end else if (!valid) begin
      res.take = 1'b1;
      res.free = 1'b1;
    end else begin
      res.take = (age > best);
    end
  end

endmodule
